FILE: design/button_click_hold_detector_defines.svh
// Assertion macros for the button click/hold detector.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define BCHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define BCHD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCHD_ASSERT(lbl, prop, msg)
`define BCHD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: design/bchd_pkg.sv
// Shared types, register codes and helpers of the button click/hold detector.
`default_nettype none

package bchd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  typedef logic [TIME_W-1:0] time_ms_t;
  typedef logic [CFG_W-1:0]  cfg_ms_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_CLICK    = 2'd2
  } cfg_idx_t;

  localparam cfg_ms_t DEBOUNCE_RST = 16'd50;
  localparam cfg_ms_t HOLD_RST     = 16'd500;
  localparam cfg_ms_t CLICK_RST    = 16'd300;

  typedef struct packed {
    cfg_ms_t debounce_ms;
    cfg_ms_t hold_ms;
    cfg_ms_t click_window_ms;
  } cfg_t;

  typedef struct packed {
    logic     press_latched;
    logic     release_pending;
    logic     click_flag;
    logic     hold_flag;
    time_ms_t edge_time;
    time_ms_t release_time;
  } state_t;

  typedef struct packed {
    logic     pin_level;
    time_ms_t now_ms;
    logic     take_click;
    logic     take_hold;
  } item_t;

  typedef struct packed {
    logic click_event;
    logic hold_event;
  } result_t;

  // Wrapping elapsed time.
  function automatic time_ms_t elapsed(input time_ms_t now, input time_ms_t then);
    return now - then;
  endfunction

  // Zero-extend a config interval to the timestamp width.
  function automatic time_ms_t widen(input cfg_ms_t v);
    return {{(TIME_W-CFG_W){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: design/bchd_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface bchd_in_if;
  logic                 valid;
  logic                 ready;
  logic                 pin_level;
  bchd_pkg::time_ms_t   now_ms;
  logic                 take_click;
  logic                 take_hold;

  modport source (output valid, pin_level, now_ms, take_click, take_hold, input ready);
  modport sink   (input valid, pin_level, now_ms, take_click, take_hold, output ready);
endinterface

interface bchd_out_if;
  logic valid;
  logic ready;
  logic click_event;
  logic hold_event;

  modport source (output valid, click_event, hold_event, input ready);
  modport sink   (input valid, click_event, hold_event, output ready);
endinterface

`default_nettype wire

FILE: design/button_click_hold_detector.sv
// Push-button click/hold detector: top level with request and result registers.
//
// Usage: each request on in_if carries one poll of the button, the raw
// active-low pin level and a wrapping millisecond timestamp, plus two
// read-and-clear bits for the click and hold events. Every request yields
// exactly one result on out_if with both event flags as they stand after
// that poll, before the clear bits act.
// A request accepted on in_if is held in the request register, evaluated
// against the detector state and passed through the result register to out_if.
// Throughput: one request per cycle while out_if takes results; the state
// update is one pass of compare-and-set logic between the request register
// and the result register.
// Stall: while the result register holds an unread result, one more
// request is still taken into the request register; in_if.ready drops only
// when both are full, and the state is not touched until the stalled result
// moves on.
// Reset (synchronous, rst_n low): both registers empty, all flags and
// timestamps zero, intervals back to 50, 500 and 300 ms. The user must write
// intervals on cfg_* only while no request is in flight (not enforced here).
`default_nettype none
`include "button_click_hold_detector_defines.svh"

module button_click_hold_detector (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bchd_in_if.sink                     in_if,
  bchd_out_if.source                  out_if,
  input  wire logic                   cfg_we,
  input  wire logic [bchd_pkg::IDX_W-1:0] cfg_idx,
  input  wire logic [bchd_pkg::CFG_W-1:0] cfg_wdata
);

  bchd_pkg::cfg_t    cfg_r;
  bchd_pkg::state_t  state_r;
  bchd_pkg::state_t  state_nxt;
  bchd_pkg::item_t   item_r;
  bchd_pkg::result_t res_nxt;
  bchd_pkg::result_t res_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= bchd_pkg::DEBOUNCE_RST;
      cfg_r.hold_ms         <= bchd_pkg::HOLD_RST;
      cfg_r.click_window_ms <= bchd_pkg::CLICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bchd_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms     <= cfg_wdata;
        bchd_pkg::CFG_HOLD:     cfg_r.hold_ms         <= cfg_wdata;
        bchd_pkg::CFG_CLICK:    cfg_r.click_window_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.pin_level  <= in_if.pin_level;
      item_r.now_ms     <= in_if.now_ms;
      item_r.take_click <= in_if.take_click;
      item_r.take_hold  <= in_if.take_hold;
    end
  end

  bchd_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.click_event = res_r.click_event;
  assign out_if.hold_event  = res_r.hold_event;

  `BCHD_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "not empty")
  `BCHD_ASSERT(a_state_frozen, (out_valid_r && !out_if.ready) |=> $stable(state_r), "state moved")
  `BCHD_ASSERT(a_req_held, (s1_valid_r && !advance) |=> s1_valid_r && $stable(item_r), "req lost")

endmodule

`default_nettype wire

FILE: design/bchd_step.sv
// Per-poll state update: debounce, click window, hold detection, read-and-clear.
`default_nettype none

module bchd_step (
  input  bchd_pkg::cfg_t    cfg,
  input  bchd_pkg::state_t  cur,
  input  bchd_pkg::item_t   item,
  output bchd_pkg::state_t  nxt,
  output bchd_pkg::result_t res
);

  always_comb begin
    bchd_pkg::state_t s;
    logic             pressed;
    s       = cur;
    pressed = !item.pin_level;

    // accept a press once the debounce interval has passed
    if (pressed && !s.press_latched &&
        bchd_pkg::elapsed(item.now_ms, s.edge_time) > bchd_pkg::widen(cfg.debounce_ms)) begin
      s.press_latched = 1'b1;
      s.edge_time     = item.now_ms;
    end

    // short press released: open the click window
    if (!pressed && s.press_latched && !s.release_pending &&
        bchd_pkg::elapsed(item.now_ms, s.edge_time) < bchd_pkg::widen(cfg.hold_ms)) begin
      s.release_pending = 1'b1;
      s.press_latched   = 1'b0;
      s.release_time    = item.now_ms;
    end

    if (s.release_pending &&
        bchd_pkg::elapsed(item.now_ms, s.release_time) >
        bchd_pkg::widen(cfg.click_window_ms)) begin
      s.release_pending = 1'b0;
      s.click_flag      = 1'b1;
    end

    if (s.press_latched && !s.hold_flag &&
        bchd_pkg::elapsed(item.now_ms, s.edge_time) > bchd_pkg::widen(cfg.hold_ms)) begin
      s.hold_flag = 1'b1;
    end

    // released after a hold: drop the press and the hold event
    if (!pressed && s.press_latched &&
        bchd_pkg::elapsed(item.now_ms, s.edge_time) > bchd_pkg::widen(cfg.hold_ms)) begin
      s.press_latched = 1'b0;
      s.hold_flag     = 1'b0;
      s.edge_time     = item.now_ms;
    end

    res.click_event = s.click_flag;
    res.hold_event  = s.hold_flag;

    if (item.take_click) begin
      s.click_flag = 1'b0;
    end
    if (item.take_hold) begin
      s.hold_flag = 1'b0;
    end

    nxt = s;
  end

endmodule

`default_nettype wire
